@@ rtl/sskl_pkg.sv @@
// Package for the stable sorted key list: field widths, operation and status codes,
// and the structs passed between the top level and the list cells.
// No dependencies.
package sskl_pkg;

  localparam int unsigned Depth   = 16;
  localparam int unsigned IdW     = 8;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned CntW    = $clog2(Depth + 1);
  localparam int unsigned OpW     = 2;
  localparam int unsigned StatusW = 2;

  // Operation codes.
  localparam logic [OpW-1:0] OP_INS_SORTED = 2'd0;
  localparam logic [OpW-1:0] OP_INS_TAIL   = 2'd1;
  localparam logic [OpW-1:0] OP_REMOVE     = 2'd2;

  // Status codes.
  localparam logic [StatusW-1:0] ST_OK      = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL    = 2'd1;
  localparam logic [StatusW-1:0] ST_MISSING = 2'd2;
  localparam logic [StatusW-1:0] ST_DUP     = 2'd3;

  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [KeyW-1:0] key;
  } entry_t;

  // Command broadcast to every cell.
  typedef struct packed {
    logic            do_ins;  // commit an insert this cycle
    logic            do_rm;   // commit a remove this cycle
    logic            sorted;  // insert point is chosen by key compare
    logic [IdW-1:0]  id;
    logic [KeyW-1:0] key;
  } cmd_t;

  // Flags that ripple from the front cell toward the tail.
  typedef struct packed {
    logic ins_seen;  // insert point is at or before this cell
    logic rm_seen;   // entry with the requested id is at or before this cell
  } chain_t;

endpackage

@@ rtl/sskl_cell.sv @@
// One list cell: holds one entry and its occupied flag, compares against the
// broadcast command and shifts toward its neighbors. Depends on sskl_pkg.
module sskl_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sskl_pkg::cmd_t   cmd_i,
  input  sskl_pkg::entry_t left_i,
  input  logic             left_used_i,
  input  sskl_pkg::entry_t right_i,
  input  logic             right_used_i,
  input  sskl_pkg::chain_t chain_i,
  output sskl_pkg::chain_t chain_o,
  output sskl_pkg::entry_t entry_o,
  output sskl_pkg::entry_t entry_d_o,
  output logic             used_o
);

  sskl_pkg::entry_t entry_q, entry_d;
  logic             used_q, used_d;
  logic             gt, match, ins_here, rm_here;

  assign gt    = cmd_i.sorted & used_q & (entry_q.key > cmd_i.key);
  assign match = used_q & (entry_q.id == cmd_i.id);

  // The first free cell is the insert point when no stored key is greater.
  assign ins_here = chain_i.ins_seen | gt | ~used_q;
  assign rm_here  = chain_i.rm_seen | match;

  assign chain_o.ins_seen = ins_here;
  assign chain_o.rm_seen  = rm_here;

  always_comb begin
    entry_d = entry_q;
    used_d  = used_q;
    if (cmd_i.do_ins) begin
      used_d = used_q | left_used_i;
      if (chain_i.ins_seen) begin
        entry_d = left_i;
      end else if (ins_here) begin
        entry_d.id  = cmd_i.id;
        entry_d.key = cmd_i.key;
      end
    end else if (cmd_i.do_rm) begin
      used_d = right_used_i;
      if (rm_here) begin
        entry_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else begin
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o   = entry_q;
  assign entry_d_o = entry_d;
  assign used_o    = used_q;

endmodule

@@ rtl/stable_sorted_key_list.sv @@
// Stable sorted key list: a row of sskl_cell instances holding the entries front
// to back, with an input register, a count and an output register.
// Depends on sskl_pkg and sskl_cell.
// A beat is captured in the input register, executed once the output register is free,
// and its result is held in the output register. The block takes no new beat until the
// current one has executed; the execute cycle ripples the compare flags through the row
// of cells, and a result waiting in the output register stalls it. Reset empties the
// list and clears all handshake state.
module stable_sorted_key_list (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // op[1:0], item_id[9:2], key[41:10], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // status[1:0], count[6:2], head_valid[7],
                                     // head_id[15:8], head_key[47:16]
);

  localparam int unsigned Depth = sskl_pkg::Depth;

  logic                            busy_q;
  logic [sskl_pkg::OpW-1:0]        op_q;
  logic [sskl_pkg::IdW-1:0]        id_q;
  logic [sskl_pkg::KeyW-1:0]       key_q;
  logic [sskl_pkg::CntW-1:0]       count_q, count_d;
  logic                            out_valid_q;
  logic [47:0]                     out_data_q;

  sskl_pkg::cmd_t                  cmd;
  sskl_pkg::chain_t                chain [Depth+1];
  sskl_pkg::entry_t                ent_q [Depth];
  sskl_pkg::entry_t                ent_d [Depth];
  logic                            used [Depth];

  logic                            in_fire, exec, out_free;
  logic                            is_ins, is_rm, found, full;
  logic [sskl_pkg::StatusW-1:0]    status;
  logic                            head_valid;
  logic [sskl_pkg::IdW-1:0]        head_id;
  logic [sskl_pkg::KeyW-1:0]       head_key;

  assign s_axis_tready = ~busy_q;
  assign in_fire       = s_axis_tvalid & ~busy_q;
  assign out_free      = ~out_valid_q | m_axis_tready;
  assign exec          = busy_q & out_free;

  assign is_ins = (op_q == sskl_pkg::OP_INS_SORTED) || (op_q == sskl_pkg::OP_INS_TAIL);
  assign is_rm  = (op_q == sskl_pkg::OP_REMOVE);
  assign found  = chain[Depth].rm_seen;
  assign full   = used[Depth-1];

  always_comb begin
    cmd.do_ins = exec & is_ins & ~found & ~full;
    cmd.do_rm  = exec & is_rm & found;
    cmd.sorted = (op_q == sskl_pkg::OP_INS_SORTED) && (key_q != '1);
    cmd.id     = id_q;
    cmd.key    = key_q;
  end

  assign chain[0].ins_seen = 1'b0;
  assign chain[0].rm_seen  = 1'b0;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    sskl_pkg::entry_t left_e, right_e;
    logic             left_u, right_u;

    if (i == 0) begin : g_front
      assign left_e = '0;
      assign left_u = 1'b1;
    end else begin : g_mid_l
      assign left_e = ent_q[i-1];
      assign left_u = used[i-1];
    end

    if (i == Depth - 1) begin : g_tail
      assign right_e = '0;
      assign right_u = 1'b0;
    end else begin : g_mid_r
      assign right_e = ent_q[i+1];
      assign right_u = used[i+1];
    end

    sskl_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .left_i       (left_e),
      .left_used_i  (left_u),
      .right_i      (right_e),
      .right_used_i (right_u),
      .chain_i      (chain[i]),
      .chain_o      (chain[i+1]),
      .entry_o      (ent_q[i]),
      .entry_d_o    (ent_d[i]),
      .used_o       (used[i])
    );
  end

  always_comb begin
    status = sskl_pkg::ST_OK;
    if (is_ins) begin
      if (found) begin
        status = sskl_pkg::ST_DUP;
      end else if (full) begin
        status = sskl_pkg::ST_FULL;
      end
    end else if (is_rm && !found) begin
      status = sskl_pkg::ST_MISSING;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd.do_ins) begin
      count_d = count_q + sskl_pkg::CntW'(1);
    end else if (cmd.do_rm) begin
      count_d = count_q - sskl_pkg::CntW'(1);
    end
  end

  // The head reflects the front cell after this command commits.
  assign head_valid = (count_d != '0);
  assign head_id    = head_valid ? ent_d[0].id  : '0;
  assign head_key   = head_valid ? ent_d[0].key : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_fire) begin
        busy_q <= 1'b1;
      end else if (exec) begin
        busy_q <= 1'b0;
      end
      if (exec) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= s_axis_tdata[1:0];
      id_q  <= s_axis_tdata[9:2];
      key_q <= s_axis_tdata[41:10];
    end
    if (exec) begin
      out_data_q <= {head_key, head_id, head_valid, count_d, status};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ test/stable_sorted_key_list_tb.sv @@
// Testbench for the stable sorted key list: drives list commands on the input stream
// and checks every result beat against a predictor that keeps its own copy of the list.
// Depends on sskl_pkg and the stable_sorted_key_list RTL.
module stable_sorted_key_list_tb;
  import sskl_pkg::*;

  // Op code 3 has no meaning in the block; it must leave the list untouched.
  localparam logic [OpW-1:0] OpUnused = 2'd3;

  typedef struct packed {
    logic [5:0]      zero_pad;
    logic [KeyW-1:0] key;
    logic [IdW-1:0]  id;
    logic [OpW-1:0]  op;
  } cmd_beat_t;

  typedef struct packed {
    logic [KeyW-1:0]    head_key;
    logic [IdW-1:0]     head_id;
    logic               head_valid;
    logic [CntW-1:0]    count;
    logic [StatusW-1:0] status;
  } report_t;

  typedef struct {
    cmd_beat_t   beat;
    int unsigned gap;
  } cmd_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  stable_sorted_key_list dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  cmd_item_t cmd_queue[$];
  report_t   report_queue[$];
  int unsigned mismatch_count = 0;
  int unsigned reports_seen = 0;

  // Predicted list contents, front entry at index 0.
  logic [KeyW-1:0] lst_key[Depth];
  logic [IdW-1:0]  lst_id[Depth];
  int              lst_count = 0;

  function automatic report_t list_apply(cmd_beat_t c);
    report_t r;
    int      at;
    int      pos;
    r.status = ST_OK;
    at = -1;
    for (int i = 0; i < lst_count; i++) begin
      if (at < 0 && lst_id[i] == c.id) at = i;
    end
    if (c.op == OP_INS_SORTED || c.op == OP_INS_TAIL) begin
      if (at >= 0) begin
        r.status = ST_DUP;
      end else if (lst_count >= Depth) begin
        r.status = ST_FULL;
      end else begin
        pos = lst_count;
        // A sorted insert stops in front of the first strictly greater key, even
        // when tail inserts have left the list out of order.
        if (c.op == OP_INS_SORTED && c.key != '1) begin
          for (int i = 0; i < lst_count; i++) begin
            if (pos == lst_count && lst_key[i] > c.key) pos = i;
          end
        end
        for (int i = lst_count; i > pos; i--) begin
          lst_key[i] = lst_key[i-1];
          lst_id[i]  = lst_id[i-1];
        end
        lst_key[pos] = c.key;
        lst_id[pos]  = c.id;
        lst_count++;
      end
    end else if (c.op == OP_REMOVE) begin
      if (at < 0) begin
        r.status = ST_MISSING;
      end else begin
        for (int i = at; i + 1 < lst_count; i++) begin
          lst_key[i] = lst_key[i+1];
          lst_id[i]  = lst_id[i+1];
        end
        lst_count--;
      end
    end
    r.count      = CntW'(lst_count);
    r.head_valid = (lst_count > 0);
    r.head_id    = (lst_count > 0) ? lst_id[0] : '0;
    r.head_key   = (lst_count > 0) ? lst_key[0] : '0;
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [KeyW-1:0] want,
                             input logic [KeyW-1:0] got);
    if (want !== got)
      flag_mismatch($sformatf("%s expected %0h, got %0h", name, want, got));
  endtask

  task automatic check_report(input report_t got);
    report_t want;
    if (report_queue.size() == 0) begin
      flag_mismatch($sformatf("result beat with nothing expected: %h", got));
    end else begin
      want = report_queue.pop_front();
      check_field("status", KeyW'(want.status), KeyW'(got.status));
      check_field("count", KeyW'(want.count), KeyW'(got.count));
      check_field("head_valid", KeyW'(want.head_valid), KeyW'(got.head_valid));
      check_field("head_id", KeyW'(want.head_id), KeyW'(got.head_id));
      check_field("head_key", want.head_key, got.head_key);
    end
  endtask

  // Command driver: a staged command waits out its gap, then is held until taken.
  cmd_item_t staged_cmd;
  cmd_beat_t live_cmd;
  bit        staged = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) report_queue.push_back(list_apply(live_cmd));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (!staged && cmd_queue.size() > 0) begin
          staged_cmd = cmd_queue.pop_front();
          staged = 1'b1;
        end
        if (staged && staged_cmd.gap == 0) begin
          live_cmd = staged_cmd.beat;
          staged = 1'b0;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= staged_cmd.beat;
        end else begin
          if (staged) staged_cmd.gap--;
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: the sink may stall at random after each beat.
  int unsigned sink_hold = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_hold = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_report(report_t'(m_axis_tdata));
        reports_seen++;
        sink_hold = (reports_seen % 120 < 30) ? 0 : $urandom_range(0, 14);
      end
      if (sink_hold != 0) begin
        sink_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic add_cmd(input logic [OpW-1:0] op, input logic [IdW-1:0] id,
                         input logic [KeyW-1:0] key, input bit no_gap);
    cmd_item_t it;
    it.beat.zero_pad = '0;
    it.beat.op       = op;
    it.beat.id       = id;
    it.beat.key      = key;
    it.gap           = no_gap ? 0 : $urandom_range(0, 14);
    cmd_queue.push_back(it);
  endtask

  initial begin
    logic [IdW-1:0]  id_mask;
    logic [KeyW-1:0] key_base;
    logic [IdW-1:0]  id;
    logic [KeyW-1:0] key;
    logic [OpW-1:0]  op;
    bit              fill_phase;
    bit              burst;
    int unsigned     roll;

    // Directed part: empty list, key extremes, equal keys, out-of-order tail
    // entries, duplicates, removes at front and tail, and a full list.
    add_cmd(OP_REMOVE, 8'h00, 32'h0, 1'b0);
    add_cmd(OpUnused, 8'hff, 32'hffff_ffff, 1'b0);
    add_cmd(OP_INS_SORTED, 8'hff, 32'hffff_ffff, 1'b0);
    add_cmd(OP_INS_SORTED, 8'h00, 32'h0, 1'b0);
    add_cmd(OP_INS_SORTED, 8'h01, 32'd100, 1'b0);
    add_cmd(OP_INS_SORTED, 8'h02, 32'd100, 1'b0);
    add_cmd(OP_INS_TAIL, 8'h03, 32'd5, 1'b0);
    add_cmd(OP_INS_SORTED, 8'h04, 32'd7, 1'b0);
    add_cmd(OP_INS_SORTED, 8'h05, 32'hffff_ffff, 1'b0);
    add_cmd(OP_INS_SORTED, 8'h01, 32'd50, 1'b0);
    add_cmd(OP_INS_TAIL, 8'h00, 32'h0, 1'b0);
    add_cmd(OpUnused, 8'h02, 32'h1234_5678, 1'b0);
    add_cmd(OP_REMOVE, 8'h00, 32'h0, 1'b0);
    add_cmd(OP_REMOVE, 8'h05, 32'hffff_ffff, 1'b0);
    add_cmd(OP_REMOVE, 8'h09, 32'h0, 1'b0);
    for (int i = 0; i < 11; i++) begin
      add_cmd((i % 3 == 0) ? OP_INS_TAIL : OP_INS_SORTED, IdW'(8'h80 + i),
              KeyW'(32'h8000_0000 - i * 3), 1'b1);
    end
    add_cmd(OP_INS_SORTED, 8'h55, 32'd1, 1'b0);
    add_cmd(OP_INS_TAIL, 8'h80, 32'h0, 1'b0);

    // Random part in segments that alternately fill and drain the list, with
    // ids from a small pool so that removes and duplicates hit often.
    for (int seg = 0; seg < 17; seg++) begin
      fill_phase = (seg % 2 == 0);
      burst      = ($urandom_range(0, 3) == 0);
      id_mask    = IdW'($urandom_range(0, 255));
      key_base   = $urandom;
      for (int n = 0; n < 50; n++) begin
        roll = $urandom_range(0, 99);
        if (fill_phase)
          op = (roll < 45) ? OP_INS_SORTED : (roll < 70) ? OP_INS_TAIL :
               (roll < 95) ? OP_REMOVE : OpUnused;
        else
          op = (roll < 20) ? OP_INS_SORTED : (roll < 30) ? OP_INS_TAIL :
               (roll < 95) ? OP_REMOVE : OpUnused;
        if ($urandom_range(0, 15) == 0) id = IdW'($urandom_range(0, 255));
        else id = IdW'($urandom_range(0, 19)) ^ id_mask;
        roll = $urandom_range(0, 99);
        if (roll < 30) key = key_base + KeyW'($urandom_range(0, 3));
        else if (roll < 40) key = '1;
        else if (roll < 45) key = '0;
        else if (roll < 50) key = '1 - KeyW'($urandom_range(1, 2));
        else key = $urandom;
        add_cmd(op, id, key, burst);
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_queue.size() != 0 || staged || s_axis_tvalid) @(posedge clk_i);
    while (report_queue.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (mismatch_count == 0 && report_queue.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
